// ===== src/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CodePointWidth = 21;
    localparam int unsigned CountWidth = 3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [ByteWidth-1:0] ASCII_MAX = 8'h7F;
    localparam logic [ByteWidth-1:0] CONT_MIN = 8'h80;
    localparam logic [ByteWidth-1:0] LEAD_MIN = 8'hC0;
    localparam logic [ByteWidth-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [ByteWidth-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [ByteWidth-1:0] LEAD_BAD_MIN = 8'hF8;

    typedef logic [CountWidth-1:0] count_t;
    typedef logic [CodePointWidth-1:0] code_point_t;

    function automatic count_t lead_length(input logic [ByteWidth-1:0] lead);
        count_t len;
        if (lead >= LEAD_BAD_MIN) begin
            len = 3'd1;
        end else if (lead >= LEAD4_MIN) begin
            len = 3'd4;
        end else if (lead >= LEAD3_MIN) begin
            len = 3'd3;
        end else if (lead >= LEAD_MIN) begin
            len = 3'd2;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

endpackage

// ===== src/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: takes one beat per cycle (kind, data_byte) and returns
// at most one code_point beat for it, in the cycle after acceptance. An ASCII byte
// passes straight through and drops any partial sequence; a lead byte starts a
// new sequence; continuation bytes are appended while one to three bytes are
// held, and the code point is emitted when the count reaches the length the
// lead byte implies. A clear beat (kind = 1) drops the partial sequence and
// gives no result. There is no overlong or surrogate check. Throughput is one
// beat per cycle: the whole update is one pass of logic from the held-sequence
// registers into a single output register, and in_ready stays high while that
// register is empty or being drained.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [ByteWidth-1:0]      data_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CodePointWidth-1:0] code_point
);

    logic [ByteWidth-1:0] lead_reg;
    logic [ByteWidth-1:0] cont1_reg;
    logic [ByteWidth-1:0] cont2_reg;
    count_t               count_reg;
    count_t               count_next;
    logic                 out_valid_reg;
    code_point_t          code_point_reg;

    logic        accept;
    logic        is_ascii;
    logic        is_lead;
    logic        is_cont;
    logic        append;
    count_t      count_inc;
    logic        complete;
    logic        emit;
    code_point_t assembled;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    assign is_ascii = (data_byte <= ASCII_MAX);
    assign is_lead = (data_byte >= LEAD_MIN);
    assign is_cont = (data_byte >= CONT_MIN) && !is_lead;

    assign append = (kind == KIND_BYTE) && is_cont
                    && (count_reg != 3'd0) && (count_reg < 3'd4);
    assign count_inc = count_reg + 3'd1;
    assign complete = append && (count_inc == lead_length(lead_reg));
    assign emit = ((kind == KIND_BYTE) && is_ascii) || complete;

    always_comb
    begin
        case (count_reg)
            3'd1:
            begin
                assembled = {10'd0, lead_reg[4:0], data_byte[5:0]};
            end
            3'd2:
            begin
                assembled = {5'd0, lead_reg[3:0], cont1_reg[5:0], data_byte[5:0]};
            end
            3'd3:
            begin
                assembled = {lead_reg[2:0], cont1_reg[5:0], cont2_reg[5:0],
                             data_byte[5:0]};
            end
            default:
            begin
                assembled = '0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (kind == KIND_CLEAR || is_ascii) begin
            count_next = 3'd0;
        end else if (is_lead) begin
            count_next = 3'd1;
        end else if (complete) begin
            count_next = 3'd0;
        end else if (append) begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
                out_valid_reg <= emit;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            if (kind == KIND_BYTE && is_lead) begin
                lead_reg <= data_byte;
            end
            if (append && count_reg == 3'd1) begin
                cont1_reg <= data_byte;
            end
            if (append && count_reg == 3'd2) begin
                cont2_reg <= data_byte;
            end
            if (emit) begin
                code_point_reg <= is_ascii ? {13'd0, data_byte} : assembled;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign code_point = code_point_reg;

endmodule

// ===== src/utf8d_checker.sv =====
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      kind,
    input logic [ByteWidth-1:0]      data_byte,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [CodePointWidth-1:0] code_point
);

    logic in_beat;
    logic out_free;

    assign in_beat = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point))
    else $error("stalled result changed");

    // no new beat taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

    // ascii passes through next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && kind == KIND_BYTE && data_byte <= ASCII_MAX
        |=> out_valid && code_point == {13'd0, $past(data_byte)})
    else $error("ascii byte not passed through");

    // clear beat gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && kind == KIND_CLEAR && out_free |=> !out_valid)
    else $error("clear beat produced a result");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point)
);
